// ===== hw/rtl/tse_pkg.sv =====
// ---------------------------------------------------------------------------
// tse_pkg
// Shared types and constants for the Maclaurin series evaluator.
// ---------------------------------------------------------------------------
package tse_pkg;

   localparam logic [63:0] ONE_Q  = 64'h0000_0001_0000_0000;
   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

   typedef enum logic [1:0] {
      ACT_COS  = 2'd0,
      ACT_SQRT = 2'd1,
      ACT_EXP  = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      B_X,
      B_X2,
      B_NCOS,
      B_INT,
      B_RCP2,
      B_RCPK
   } bsel_type;

   typedef enum logic [1:0] {
      OUT_SUM,
      OUT_RANGE,
      OUT_ZERO
   } omode_type;

   typedef struct packed {
      logic      start;
      logic      mul_load;
      logic      use_x;
      bsel_type  b_sel;
      logic      mul_en;
      logic [1:0] mul_idx;
      logic      acc_en;
      logic [1:0] acc_idx;
      logic      mul_fin;
      logic      dest_x2;
      logic      add;
      logic      out_load;
      omode_type out_mode;
   } cmd_type;

   typedef struct packed {
      logic x_big;
   } status_type;

endpackage

// ===== hw/rtl/tse_ctrl.sv =====
// ---------------------------------------------------------------------------
// tse_ctrl
// Sequencer: walks the term recurrence, issues multiply, add and output
// commands to the datapath and runs both handshakes.
// ---------------------------------------------------------------------------
module tse_ctrl #(
   parameter int MAX_TERMS = 16,
   parameter int KW        = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [3:0]           req_term_count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tse_pkg::cmd_type     cmd,
   output logic [KW-1:0]        k_idx,
   input  tse_pkg::status_type  status
);
   import tse_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MLOAD,
      S_MPP,
      S_MFIN,
      S_ADD,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_X2,
      OP_COS1,
      OP_COS2,
      OP_SQ1,
      OP_SQ2,
      OP_SQ3,
      OP_EX1,
      OP_EX2
   } op_type;

   state_type  state_ff;
   op_type     op_ff;
   action_type act_ff;
   omode_type  mode_ff;
   logic [KW-1:0] k_ff;
   logic [KW-1:0] n_ff;
   logic [2:0]    cnt_ff;
   logic          rsp_valid_ff;
   logic [KW-1:0] nlim;
   logic          out_free;

   function automatic op_type first_op(input action_type act);
      op_type op;
      unique case (act)
         ACT_COS:  op = OP_COS1;
         ACT_SQRT: op = OP_SQ1;
         default:  op = OP_EX1;
      endcase
      return op;
   endfunction

   always_comb begin
      if ({2'b00, req_term_count} > 6'(MAX_TERMS - 1)) begin
         nlim = KW'(MAX_TERMS - 1);
      end else begin
         nlim = KW'(req_term_count);
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign k_idx     = k_ff;

   always_comb begin
      cmd          = '0;
      cmd.start    = (state_ff == S_IDLE) && req_valid;
      cmd.mul_load = (state_ff == S_MLOAD);
      cmd.use_x    = (op_ff == OP_X2);
      unique case (op_ff)
         OP_COS1: cmd.b_sel = B_X2;
         OP_COS2: cmd.b_sel = B_NCOS;
         OP_SQ2:  cmd.b_sel = B_INT;
         OP_SQ3:  cmd.b_sel = B_RCP2;
         OP_EX2:  cmd.b_sel = B_RCPK;
         default: cmd.b_sel = B_X;
      endcase
      cmd.mul_en   = (state_ff == S_MPP) && (cnt_ff != 3'd4);
      cmd.mul_idx  = cnt_ff[1:0];
      cmd.acc_en   = (state_ff == S_MPP) && (cnt_ff != 3'd0);
      cmd.acc_idx  = cnt_ff[1:0] - 2'd1;
      cmd.mul_fin  = (state_ff == S_MFIN);
      cmd.dest_x2  = (op_ff == OP_X2);
      cmd.add      = (state_ff == S_ADD);
      cmd.out_load = (state_ff == S_FINISH) && out_free;
      cmd.out_mode = mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_X2;
         act_ff       <= ACT_NONE;
         mode_ff      <= OUT_ZERO;
         k_ff         <= '0;
         n_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  act_ff   <= action_type'(req_action);
                  n_ff     <= nlim;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               k_ff <= KW'(1);
               priority if (act_ff == ACT_NONE) begin
                  mode_ff  <= OUT_ZERO;
                  state_ff <= S_FINISH;
               end else if (act_ff == ACT_SQRT && status.x_big) begin
                  mode_ff  <= OUT_RANGE;
                  state_ff <= S_FINISH;
               end else if (act_ff == ACT_COS) begin
                  mode_ff  <= OUT_SUM;
                  op_ff    <= OP_X2;
                  state_ff <= S_MLOAD;
               end else if (n_ff == '0) begin
                  mode_ff  <= OUT_SUM;
                  state_ff <= S_FINISH;
               end else begin
                  mode_ff  <= OUT_SUM;
                  op_ff    <= first_op(act_ff);
                  state_ff <= S_MLOAD;
               end
            end
            S_MLOAD: begin
               cnt_ff   <= '0;
               state_ff <= S_MPP;
            end
            S_MPP: begin
               if (cnt_ff == 3'd4) begin
                  state_ff <= S_MFIN;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_MFIN: begin
               unique case (op_ff)
                  OP_X2: begin
                     if (n_ff == '0) begin
                        state_ff <= S_FINISH;
                     end else begin
                        op_ff    <= OP_COS1;
                        state_ff <= S_MLOAD;
                     end
                  end
                  OP_COS1: begin
                     op_ff    <= OP_COS2;
                     state_ff <= S_MLOAD;
                  end
                  OP_SQ1: begin
                     op_ff    <= OP_SQ2;
                     state_ff <= S_MLOAD;
                  end
                  OP_SQ2: begin
                     op_ff    <= OP_SQ3;
                     state_ff <= S_MLOAD;
                  end
                  OP_EX1: begin
                     op_ff    <= OP_EX2;
                     state_ff <= S_MLOAD;
                  end
                  default: begin
                     state_ff <= S_ADD;
                  end
               endcase
            end
            S_ADD: begin
               if (k_ff == n_ff) begin
                  state_ff <= S_FINISH;
               end else begin
                  k_ff     <= k_ff + KW'(1);
                  op_ff    <= first_op(act_ff);
                  state_ff <= S_MLOAD;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/tse_dpath.sv =====
// ---------------------------------------------------------------------------
// tse_dpath
// Datapath: Q32.32 term and sum registers, a 32x32 multiplier stepped over
// four partial products with saturation, a saturating adder, reciprocal
// tables and the result register.
// ---------------------------------------------------------------------------
module tse_dpath #(
   parameter int MAX_TERMS     = 16,
   parameter int ARG_FRAC_BITS = 28,
   parameter int KW            = 4
) (
   input  logic                clock,
   input  tse_pkg::cmd_type    cmd,
   input  logic [KW-1:0]       k_idx,
   output tse_pkg::status_type status,
   input  logic signed [31:0]  req_arg_x,
   output logic signed [63:0]  rsp_series_sum,
   output logic signed [63:0]  rsp_last_term,
   output logic                rsp_range_error,
   output logic                rsp_overflow
);
   import tse_pkg::*;

   logic [63:0] rcp_k   [MAX_TERMS];
   logic [63:0] rcp_2k  [MAX_TERMS];
   logic [63:0] rcp_cos [MAX_TERMS];

   for (genvar g = 0; g < MAX_TERMS; g++) begin : g_rcp
      if (g == 0) begin : g_zero
         assign rcp_k[g]   = '0;
         assign rcp_2k[g]  = '0;
         assign rcp_cos[g] = '0;
      end else begin : g_val
         localparam logic [63:0] RK = 64'h1_0000_0000 / 64'(g);
         localparam logic [63:0] R2 = 64'h1_0000_0000 / 64'(2 * g);
         localparam logic [63:0] RC = 64'h1_0000_0000 / 64'((2 * g - 1) * 2 * g);
         assign rcp_k[g]   = RK;
         assign rcp_2k[g]  = R2;
         assign rcp_cos[g] = RC;
      end
   end

   logic [63:0] x_ff, x_in;
   logic [63:0] x2_ff, x2_in;
   logic [63:0] term_ff, term_in;
   logic [63:0] sum_ff, sum_in;
   logic        ovf_ff, ovf_in;
   logic [63:0] ma_ff, ma_in;
   logic [63:0] mb_ff, mb_in;
   logic        neg_ff, neg_in;
   logic [63:0] p_ff, p_in;
   logic [95:0] acc_ff, acc_in;
   logic [63:0] osum_ff, osum_in;
   logic [63:0] oterm_ff, oterm_in;
   logic        orange_ff, orange_in;
   logic        oovf_ff, oovf_in;

   logic [63:0] xq;
   logic [63:0] x_mag;
   logic [63:0] a_val;
   logic [63:0] b_val;
   logic [KW:0] cmag;
   logic [63:0] ipos;
   logic [31:0] a_half;
   logic [31:0] b_half;
   logic [63:0] lim;
   logic [63:0] r_raw;
   logic        mul_sat;
   logic [63:0] r_sat;
   logic [63:0] mul_res;
   logic [63:0] add_raw;
   logic        add_sat;

   assign xq     = {{32{req_arg_x[31]}}, req_arg_x} << (32 - ARG_FRAC_BITS);
   assign x_mag  = x_ff[63] ? (64'd0 - x_ff) : x_ff;
   assign status.x_big = (x_mag > ONE_Q);

   assign cmag = (k_idx == KW'(1)) ? (KW + 1)'(1) : ({k_idx, 1'b0} - (KW + 1)'(3));
   assign ipos = 64'(cmag) << 32;

   assign a_val = cmd.use_x ? x_ff : term_ff;

   always_comb begin
      unique case (cmd.b_sel)
         B_X2:    b_val = x2_ff;
         B_NCOS:  b_val = 64'd0 - rcp_cos[k_idx];
         B_INT:   b_val = (k_idx == KW'(1)) ? ipos : (64'd0 - ipos);
         B_RCP2:  b_val = rcp_2k[k_idx];
         B_RCPK:  b_val = rcp_k[k_idx];
         default: b_val = x_ff;
      endcase
   end

   assign a_half = cmd.mul_idx[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_half = cmd.mul_idx[0] ? mb_ff[63:32] : mb_ff[31:0];

   assign lim     = neg_ff ? SIGN64 : (SIGN64 - 64'd1);
   assign r_raw   = acc_ff[63:0];
   assign mul_sat = (acc_ff[95:64] != 32'd0) || (r_raw > lim);
   assign r_sat   = mul_sat ? lim : r_raw;
   assign mul_res = neg_ff ? (64'd0 - r_sat) : r_sat;

   assign add_raw = sum_ff + term_ff;
   assign add_sat = !(sum_ff[63] ^ term_ff[63]) && (sum_ff[63] ^ add_raw[63]);

   always_comb begin
      x_in      = x_ff;
      x2_in     = x2_ff;
      term_in   = term_ff;
      sum_in    = sum_ff;
      ovf_in    = ovf_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      neg_in    = neg_ff;
      p_in      = p_ff;
      acc_in    = acc_ff;
      osum_in   = osum_ff;
      oterm_in  = oterm_ff;
      orange_in = orange_ff;
      oovf_in   = oovf_ff;

      if (cmd.start) begin
         x_in    = xq;
         term_in = ONE_Q;
         sum_in  = ONE_Q;
         ovf_in  = 1'b0;
      end

      if (cmd.mul_load) begin
         ma_in  = a_val[63] ? (64'd0 - a_val) : a_val;
         mb_in  = b_val[63] ? (64'd0 - b_val) : b_val;
         neg_in = a_val[63] ^ b_val[63];
      end

      if (cmd.mul_en) begin
         p_in = 64'(a_half) * 64'(b_half);
      end

      if (cmd.acc_en) begin
         unique case (cmd.acc_idx)
            2'd0:    acc_in = {64'd0, p_ff[63:32]};
            2'd3:    acc_in = acc_ff + {p_ff, 32'd0};
            default: acc_in = acc_ff + {32'd0, p_ff};
         endcase
      end

      if (cmd.mul_fin) begin
         if (cmd.dest_x2) begin
            x2_in = mul_res;
         end else begin
            term_in = mul_res;
         end
         ovf_in = ovf_ff | mul_sat;
      end

      if (cmd.add) begin
         if (add_sat) begin
            sum_in = sum_ff[63] ? SIGN64 : (SIGN64 - 64'd1);
         end else begin
            sum_in = add_raw;
         end
         ovf_in = ovf_ff | add_sat;
      end

      if (cmd.out_load) begin
         unique case (cmd.out_mode)
            OUT_SUM: begin
               osum_in   = sum_ff;
               oterm_in  = term_ff;
               orange_in = 1'b0;
               oovf_in   = ovf_ff;
            end
            OUT_RANGE: begin
               osum_in   = '0;
               oterm_in  = '0;
               orange_in = 1'b1;
               oovf_in   = 1'b0;
            end
            default: begin
               osum_in   = '0;
               oterm_in  = '0;
               orange_in = 1'b0;
               oovf_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      x2_ff     <= x2_in;
      term_ff   <= term_in;
      sum_ff    <= sum_in;
      ovf_ff    <= ovf_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      neg_ff    <= neg_in;
      p_ff      <= p_in;
      acc_ff    <= acc_in;
      osum_ff   <= osum_in;
      oterm_ff  <= oterm_in;
      orange_ff <= orange_in;
      oovf_ff   <= oovf_in;
   end

   assign rsp_series_sum  = osum_ff;
   assign rsp_last_term   = oterm_ff;
   assign rsp_range_error = orange_ff;
   assign rsp_overflow    = oovf_ff;

endmodule

// ===== hw/rtl/taylor_series_evaluator.sv =====
// ---------------------------------------------------------------------------
// taylor_series_evaluator
// Partial Maclaurin sums of cos(x), sqrt(1+x) and e^x in Q32.32, with the
// last term, a range flag and a saturation flag.
//
//   channel | ports                                         | dir
//   --------+-----------------------------------------------+-----
//   req     | req_valid/ready, action, term_count, arg_x    | in
//   rsp     | rsp_valid/ready, series_sum, last_term, flags | out
//
// Each multiply runs on one shared 32x32 multiplier (operand
// load, four partial products plus accumulate, saturate). A term takes
// two multiplies and an add for exp, three multiplies and an add for sqrt
// and two and an add for cos, plus one x^2 multiply once per cos beat.
// One beat is in flight at a time; the next is taken while a result waits.
// Synchronous active-high reset clears the sequencer; no clearing pass.
// ---------------------------------------------------------------------------
module taylor_series_evaluator #(
   parameter int MAX_TERMS     = 16,
   parameter int ARG_FRAC_BITS = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_term_count,
   input  logic signed [31:0] req_arg_x,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_series_sum,
   output logic signed [63:0] rsp_last_term,
   output logic               rsp_range_error,
   output logic               rsp_overflow
);
   import tse_pkg::*;

   localparam int KW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [KW-1:0] k_idx;

   tse_ctrl #(
      .MAX_TERMS (MAX_TERMS),
      .KW        (KW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_term_count (req_term_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd),
      .k_idx          (k_idx),
      .status         (status)
   );

   tse_dpath #(
      .MAX_TERMS     (MAX_TERMS),
      .ARG_FRAC_BITS (ARG_FRAC_BITS),
      .KW            (KW)
   ) u_dpath (
      .clock           (clock),
      .cmd             (cmd),
      .k_idx           (k_idx),
      .status          (status),
      .req_arg_x       (req_arg_x),
      .rsp_series_sum  (rsp_series_sum),
      .rsp_last_term   (rsp_last_term),
      .rsp_range_error (rsp_range_error),
      .rsp_overflow    (rsp_overflow)
   );

endmodule
